// ===== rtl/core/atrs_pkg.sv =====
// ============================================================================
// atrs_pkg
// Shared types and constants for the analog test ramp sequencer core.
// ============================================================================
package atrs_pkg;

  // Test phase codes
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_RISING  = 2'd1;
  localparam logic [1:0] PH_HOLDING = 2'd2;
  localparam logic [1:0] PH_FALLING = 2'd3;

  // Host switch command codes
  localparam logic [1:0] CMD_NONE = 2'd0;
  localparam logic [1:0] CMD_ON   = 2'd1;
  localparam logic [1:0] CMD_OFF  = 2'd2;

  // Configuration register word indexes
  localparam logic REG_CHANNEL   = 1'b0;
  localparam logic REG_AMPLITUDE = 1'b1;

  // Reset values of the configuration registers
  localparam logic [2:0]        CHANNEL_RESET   = 3'd1;
  localparam logic signed [7:0] AMPLITUDE_RESET = 8'sd5;

  // Ramp constants
  localparam logic [15:0]        MID_CODE        = 16'h8000;
  localparam logic [15:0]        COUNTS_PER_VOLT = 16'd3270;
  localparam logic signed [16:0] RAMP_STEP       = 17'sd655;
  localparam logic signed [7:0]  AMP_LIMIT_POS   = 8'sd10;
  localparam logic signed [7:0]  AMP_LIMIT_NEG   = -8'sd10;
  localparam logic signed [15:0] FB_LIMIT_POS    = 16'sd5;
  localparam logic signed [15:0] FB_LIMIT_NEG    = -16'sd5;
  localparam logic signed [16:0] HOLD_TICKS      = 17'sd10;

  // Sequencer state carried from tick to tick
  typedef struct packed {
    logic [1:0]        phase;
    logic signed [16:0] level;   // ramp level, or hold counter while holding
    logic [15:0]       target;
    logic signed [4:0] amp;      // latched amplitude, -10..10
    logic              sw;       // test switch; also the previous-tick switch
  } atrs_state_t;

  // One result per tick
  typedef struct packed {
    logic        write_valid;
    logic [1:0]  write_channel;
    logic [15:0] write_value;
    logic        switch_on;
    logic [1:0]  test_phase;
  } atrs_result_t;

endpackage

// ===== rtl/core/analog_test_ramp_sequencer_core.sv =====
// ============================================================================
// analog_test_ramp_sequencer_core
// Analog output test ramp sequencer, advanced by one request per timer tick.
// ============================================================================
//
//  Channel   Direction  Handshake                 Payload
//  in_*      slave      in_tvalid / in_tready     switch_cmd, feedback_one, feedback_two
//  out_*     master     out_tvalid / out_tready   write_valid (tuser), channel, value,
//                                                 switch, phase
//  cfg_*     APB slave  psel, penable, pready     test_channel @0x0, test_amplitude @0x4
//
//  One request per cycle sustained while out_tready is high; a request goes through the
//  input register, then the result register, with the whole tick evaluated between them.
//  Sequencer state updates when a request moves into the result register.
//  A stalled result register holds one result while the input register takes
//  one more request. Reset is synchronous, active low, and needs no clearing pass.
//
module analog_test_ramp_sequencer_core import atrs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,    // [1:0] switch_cmd, [17:2] feedback_one,
                                   // [33:18] feedback_two, [39:34] zero
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // [1:0] write_channel, [17:2] write_value,
                                   // [18] switch_on, [20:19] test_phase, [23:21] zero
  output logic        out_tuser,   // [0] write_valid
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic               cfg_wr;
  logic [2:0]         channel_r;
  logic signed [7:0]  amplitude_r;

  logic               s1_valid_r;
  logic [1:0]         s1_cmd_r;
  logic signed [15:0] s1_fb1_r;
  logic signed [15:0] s1_fb2_r;

  logic               out_valid_r;
  atrs_result_t       out_res_r;
  atrs_state_t        state_r;
  atrs_state_t        state_nxt;
  atrs_result_t       step_res;

  logic               in_accept;
  logic               out_free;
  logic               s1_valid_nxt;

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_r   <= CHANNEL_RESET;
      amplitude_r <= AMPLITUDE_RESET;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_CHANNEL) channel_r   <= cfg_pwdata[2:0];
      else                             amplitude_r <= $signed(cfg_pwdata[7:0]);
    end
  end

  always_comb begin
    if (cfg_paddr[2] == REG_AMPLITUDE) cfg_prdata = 32'($signed(amplitude_r));
    else                               cfg_prdata = {29'd0, channel_r};
  end

  // Flow control between the input and result registers
  assign out_free     = !out_valid_r || out_tready;
  assign in_tready    = !s1_valid_r || out_free;
  assign in_accept    = in_tvalid && in_tready;
  assign s1_valid_nxt = in_accept || (s1_valid_r && !out_free);

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) s1_valid_r <= 1'b0;
    else        s1_valid_r <= s1_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_cmd_r <= in_tdata[1:0];
      s1_fb1_r <= $signed(in_tdata[17:2]);
      s1_fb2_r <= $signed(in_tdata[33:18]);
    end
  end

  // Tick evaluation
  atrs_step u_step (
    .state_cur      (state_r),
    .switch_cmd     (s1_cmd_r),
    .feedback_one   (s1_fb1_r),
    .feedback_two   (s1_fb2_r),
    .test_channel   (channel_r),
    .test_amplitude (amplitude_r),
    .state_nxt      (state_nxt),
    .result         (step_res)
  );

  // Sequencer state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid_r) out_res_r <= step_res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.write_valid;
  assign out_tdata  = {3'd0, out_res_r.test_phase, out_res_r.switch_on,
                       out_res_r.write_value, out_res_r.write_channel};

`ifndef SYNTHESIS
  // an active test phase always has the switch on
  a_phase_needs_switch: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.phase != PH_IDLE) |-> state_r.sw)
    else $error("active phase with test switch off");

  // hold counter stays within the hold window
  a_hold_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.phase == PH_HOLDING) |-> (state_r.level >= 17'sd1 && state_r.level <= HOLD_TICKS))
    else $error("hold counter out of range");

  // an empty result register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty result register");
`endif

endmodule

// ===== rtl/core/atrs_step.sv =====
// ============================================================================
// atrs_step
// Next-state and result logic for one tick of the ramp sequencer.
// ============================================================================
module atrs_step import atrs_pkg::*; (
  input  atrs_state_t        state_cur,
  input  logic [1:0]         switch_cmd,
  input  logic signed [15:0] feedback_one,
  input  logic signed [15:0] feedback_two,
  input  logic [2:0]         test_channel,
  input  logic signed [7:0]  test_amplitude,
  output atrs_state_t        state_nxt,
  output atrs_result_t       result
);

  // Offset-binary output for the current level and sign of the amplitude
  function automatic logic [15:0] drive_code(input logic signed [4:0] amp,
                                             input logic signed [16:0] lvl);
    logic signed [16:0] sum;
    begin
      if (amp > 5'sd0) sum = $signed({1'b0, MID_CODE}) + lvl;
      else             sum = $signed({1'b0, MID_CODE}) - lvl;
      drive_code = sum[15:0];
    end
  endfunction

  logic               chan_ok;
  logic [1:0]         chan_idx;
  logic               fb_trip;
  logic signed [4:0]  amp_clamped;
  logic signed [4:0]  amp_neg;
  logic [3:0]         amp_mag;

  logic               sw;
  logic [1:0]         ph;
  logic signed [16:0] lv;
  logic [15:0]        tg;
  logic signed [4:0]  la;
  logic               wv;
  logic [15:0]        val;

  assign chan_ok  = (test_channel >= 3'd1) && (test_channel <= 3'd4);
  assign chan_idx = 2'(test_channel - 3'd1);

  // Feedback abort check on channels one and two
  assign fb_trip =
      ((test_channel == 3'd1) && (feedback_one > FB_LIMIT_POS || feedback_one < FB_LIMIT_NEG)) ||
      ((test_channel == 3'd2) && (feedback_two > FB_LIMIT_POS || feedback_two < FB_LIMIT_NEG));

  // Saturate the amplitude and take its magnitude
  always_comb begin
    if (test_amplitude < AMP_LIMIT_NEG)      amp_clamped = 5'(AMP_LIMIT_NEG);
    else if (test_amplitude > AMP_LIMIT_POS) amp_clamped = 5'(AMP_LIMIT_POS);
    else                                     amp_clamped = test_amplitude[4:0];
  end
  assign amp_neg = -amp_clamped;
  assign amp_mag = amp_clamped[4] ? amp_neg[3:0] : amp_clamped[3:0];

  // Phase cascade: a tick can pass through several phases in order
  always_comb begin
    sw  = state_cur.sw;
    ph  = state_cur.phase;
    lv  = state_cur.level;
    tg  = state_cur.target;
    la  = state_cur.amp;
    wv  = 1'b0;
    val = '0;

    if (switch_cmd == CMD_ON)       sw = 1'b1;
    else if (switch_cmd == CMD_OFF) sw = 1'b0;

    if (sw) begin
      // start a new test
      if (ph == PH_IDLE && chan_ok) begin
        la = amp_clamped;
        tg = 16'(COUNTS_PER_VOLT * {12'd0, amp_mag});
        lv = '0;
        ph = PH_RISING;
      end
      // ramp up
      if (ph == PH_RISING) begin
        if (chan_ok) begin
          wv  = 1'b1;
          val = drive_code(la, lv);
        end
        lv = lv + RAMP_STEP;
        if (lv >= $signed({1'b0, tg})) begin
          ph = PH_HOLDING;
          lv = '0;
        end
        if (fb_trip) begin
          ph = PH_IDLE;
          sw = 1'b0;
        end
      end
      // hold count
      if (ph == PH_HOLDING) begin
        lv = lv + 17'sd1;
        if (lv > HOLD_TICKS) begin
          ph = PH_FALLING;
          lv = $signed({1'b0, tg});
        end
      end
      // ramp down
      if (ph == PH_FALLING) begin
        if (chan_ok) begin
          wv  = 1'b1;
          val = drive_code(la, lv);
        end
        lv = lv - RAMP_STEP;
        if (lv <= 17'sd0) begin
          ph = PH_IDLE;
          sw = 1'b0;
        end
      end
    end

    // switch just went off: park the output at mid code
    if (!sw && state_cur.sw) begin
      ph = PH_IDLE;
      if (chan_ok) begin
        wv  = 1'b1;
        val = MID_CODE;
      end
    end
  end

  assign state_nxt.phase  = ph;
  assign state_nxt.level  = lv;
  assign state_nxt.target = tg;
  assign state_nxt.amp    = la;
  assign state_nxt.sw     = sw;

  assign result.write_valid   = wv;
  assign result.write_channel = wv ? chan_idx : 2'd0;
  assign result.write_value   = val;
  assign result.switch_on     = sw;
  assign result.test_phase    = ph;

endmodule

// ===== dv/atrs_ramp_scoreboard_pkg.sv =====
// ============================================================================
// atrs_ramp_scoreboard_pkg
// Tick-level prediction and result checking for the ramp sequencer bench.
// ============================================================================
package atrs_ramp_scoreboard_pkg;
  import atrs_pkg::*;

  // Switch command code with no effect on the sequencer
  localparam logic [1:0] CMD_RESERVED = 2'd3;

  class ramp_scoreboard;
    // Shadow copy of the configuration registers
    logic [2:0]        channel;
    logic signed [7:0] amplitude;

    // Shadow sequencer state
    logic [1:0] phase;
    int         level;
    int         target;
    int         amp_held;
    bit         sw;
    bit         sw_prev;

    // Result being built for the current tick, and those still owed
    atrs_result_t tick_result;
    atrs_result_t pending_ticks[$];

    // Run statistics
    int errors;
    int requests;
    int results;
    int writes;
    int completions;
    int aborts;

    function new();
      channel     = CHANNEL_RESET;
      amplitude   = AMPLITUDE_RESET;
      phase       = PH_IDLE;
      level       = 0;
      target      = 0;
      amp_held    = 0;
      sw          = 1'b0;
      sw_prev     = 1'b0;
      errors      = 0;
      requests    = 0;
      results     = 0;
      writes      = 0;
      completions = 0;
      aborts      = 0;
    endfunction

    function void set_register(logic idx, logic [31:0] value);
      if (idx == REG_CHANNEL) begin
        channel = value[2:0];
      end else begin
        amplitude = value[7:0];
      end
    endfunction

    function bit channel_live();
      return channel >= 3'd1 && channel <= 3'd4;
    endfunction

    // Later writes in the same tick overwrite earlier ones
    function void post_write(int code);
      logic [2:0] idx;
      if (!channel_live()) return;
      idx = channel - 3'd1;
      tick_result.write_valid   = 1'b1;
      tick_result.write_channel = idx[1:0];
      tick_result.write_value   = code[15:0];
    endfunction

    function int ramp_code();
      return (amp_held > 0) ? int'(MID_CODE) + level : int'(MID_CODE) - level;
    endfunction

    function int outstanding();
      return pending_ticks.size();
    endfunction

    // One accepted tick request: advance the shadow state, queue the result
    function void tick_accepted(logic [1:0] cmd, logic signed [15:0] fb_one,
                                logic signed [15:0] fb_two);
      int a;
      bit trip;
      tick_result = '0;
      requests++;

      if (cmd == CMD_ON) begin
        sw = 1'b1;
      end else if (cmd == CMD_OFF) begin
        sw = 1'b0;
      end

      if (sw) begin
        // start: latch saturated amplitude
        if (phase == PH_IDLE && channel_live()) begin
          a = amplitude;
          if (a < AMP_LIMIT_NEG) a = AMP_LIMIT_NEG;
          if (a > AMP_LIMIT_POS) a = AMP_LIMIT_POS;
          amp_held = a;
          target   = int'(COUNTS_PER_VOLT) * ((a < 0) ? -a : a);
          level    = 0;
          phase    = PH_RISING;
        end
        // ramp up, with feedback guard on channels 1 and 2
        if (phase == PH_RISING) begin
          post_write(ramp_code());
          level += int'(RAMP_STEP);
          if (level >= target) begin
            phase = PH_HOLDING;
            level = 0;
          end
          trip = (channel == 3'd1 && (fb_one > FB_LIMIT_POS || fb_one < FB_LIMIT_NEG)) ||
                 (channel == 3'd2 && (fb_two > FB_LIMIT_POS || fb_two < FB_LIMIT_NEG));
          if (trip) begin
            phase = PH_IDLE;
            sw    = 1'b0;
            aborts++;
          end
        end
        // hold counter
        if (phase == PH_HOLDING) begin
          level++;
          if (level > int'(HOLD_TICKS)) begin
            phase = PH_FALLING;
            level = target;
          end
        end
        // ramp down
        if (phase == PH_FALLING) begin
          post_write(ramp_code());
          level -= int'(RAMP_STEP);
          if (level <= 0) begin
            phase = PH_IDLE;
            sw    = 1'b0;
            completions++;
          end
        end
      end

      // switch just dropped: back to zero volts
      if (!sw && sw_prev) begin
        phase = PH_IDLE;
        post_write(int'(MID_CODE));
      end
      sw_prev = sw;

      tick_result.switch_on  = sw;
      tick_result.test_phase = phase;
      pending_ticks.push_back(tick_result);
    endfunction

    // One accepted result beat, compared with the oldest owed result
    function void result_arrived(logic [23:0] data, logic user);
      atrs_result_t got;
      atrs_result_t want;
      got.write_valid   = user;
      got.write_channel = data[1:0];
      got.write_value   = data[17:2];
      got.switch_on     = data[18];
      got.test_phase    = data[20:19];
      results++;
      if (got.write_valid) writes++;

      if (pending_ticks.size() == 0) begin
        $error("result with no request outstanding: tdata %h tuser %b", data, user);
        errors++;
        return;
      end
      want = pending_ticks.pop_front();

      if (got.write_valid !== want.write_valid) begin
        $error("write_valid: expected %0h, got %0h", want.write_valid, got.write_valid);
        errors++;
      end
      if (got.write_channel !== want.write_channel) begin
        $error("write_channel: expected %0h, got %0h", want.write_channel,
               got.write_channel);
        errors++;
      end
      if (got.write_value !== want.write_value) begin
        $error("write_value: expected %0h, got %0h", want.write_value, got.write_value);
        errors++;
      end
      if (got.switch_on !== want.switch_on) begin
        $error("switch_on: expected %0h, got %0h", want.switch_on, got.switch_on);
        errors++;
      end
      if (got.test_phase !== want.test_phase) begin
        $error("test_phase: expected %0h, got %0h", want.test_phase, got.test_phase);
        errors++;
      end
    endfunction
  endclass

endpackage

// ===== dv/tb.sv =====
// ============================================================================
// tb
// Bench for the analog test ramp sequencer core: directed ticks for the
// corner cases, then random sessions of switch commands and feedback with
// register changes between them, random gaps on both streams.
// ============================================================================
module tb;
  import atrs_pkg::*;
  import atrs_ramp_scoreboard_pkg::*;

  localparam int TICK_TARGET = 1150;
  localparam int IDLE_LIMIT  = 2000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // [1:0] switch_cmd, [17:2] feedback_one,
                                // [33:18] feedback_two, [39:34] zero
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // [1:0] write_channel, [17:2] write_value,
                                // [18] switch_on, [20:19] test_phase
  logic        out_tuser;       // [0] write_valid
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  ramp_scoreboard sb;
  bit steady = 1'b0;   // no gaps on either side while set

  // Handshakes seen at the falling edge, taking effect at the next rise
  logic        in_seen = 1'b0;
  logic        out_seen = 1'b0;
  logic        cfg_seen = 1'b0;
  logic [23:0] out_seen_data;
  logic        out_seen_user;
  int          stall_left = 0;

  analog_test_ramp_sequencer_core i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(13, 60);
  endfunction

  // Sample handshakes where all signals are settled
  always @(negedge clk) begin
    in_seen       = rst_n && in_tvalid && in_tready;
    out_seen      = rst_n && out_tvalid && out_tready;
    cfg_seen      = rst_n && cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
    out_seen_data = out_tdata;
    out_seen_user = out_tuser;
  end

  // Result side: check accepted beats, stall at random
  always @(posedge clk) begin
    if (out_seen) sb.result_arrived(out_seen_data, out_seen_user);
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  // Watchdog on cycles without any transfer
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (in_seen || out_seen || cfg_seen) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // APB write: setup then access; mirrored into the predictor
  task automatic program_register(input logic idx, input logic [31:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sb.set_register(idx, value);
  endtask

  // One tick request; returns at the edge that accepted it
  task automatic send_tick(input logic [1:0] cmd, input logic [15:0] fb_one,
                           input logic [15:0] fb_two);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, fb_two, fb_one, cmd};
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    sb.tick_accepted(cmd, fb_one, fb_two);
  endtask

  // Stop sending and wait for every owed result
  task automatic drain_ticks();
    in_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  function automatic logic [2:0] pick_channel();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 30) return 3'd1;
    if (roll < 60) return 3'd2;
    if (roll < 75) return 3'd3;
    if (roll < 90) return 3'd4;
    return ($urandom_range(0, 1) != 0) ? 3'd0 : 3'($urandom_range(5, 7));
  endfunction

  function automatic int pick_amplitude();
    int roll;
    int corners[7];
    corners = '{-128, 127, -11, 11, -10, 10, 0};
    roll = $urandom_range(0, 99);
    if (roll < 40) return $urandom_range(0, 6) - 3;
    if (roll < 65) return $urandom_range(0, 20) - 10;
    if (roll < 80) return corners[$urandom_range(0, 6)];
    return $urandom_range(0, 255) - 128;
  endfunction

  function automatic logic [1:0] pick_command();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 88) return CMD_NONE;
    if (roll < 93) return CMD_ON;
    if (roll < 97) return CMD_OFF;
    return CMD_RESERVED;
  endfunction

  // Quiet feedback stays within the guard band; noise goes anywhere
  function automatic logic [15:0] pick_feedback(int noise_pct);
    int v;
    if ($urandom_range(0, 99) >= noise_pct) begin
      v = $urandom_range(0, 10) - 5;
      return v[15:0];
    end
    case ($urandom_range(0, 3))
      0: return 16'd6;
      1: return 16'hFFFA;
      default: return 16'($urandom());
    endcase
  endfunction

  initial begin
    int noise;
    int len;
    int k;
    logic [1:0] cmd;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reserved command and feedback extremes while idle
    send_tick(CMD_RESERVED, 16'h8000, 16'h7FFF);
    send_tick(CMD_NONE, 16'h7FFF, 16'h8000);

    // saturated negative amplitude on channel 1, then feedback abort;
    // the abort tick also carries the exit write
    drain_ticks();
    program_register(REG_AMPLITUDE, 32'hFFFF_FF80);
    send_tick(CMD_ON, 16'd0, 16'd0);
    send_tick(CMD_NONE, 16'd5, 16'h8000);
    send_tick(CMD_NONE, 16'hFFFB, 16'h7FFF);
    send_tick(CMD_NONE, 16'd6, 16'd0);

    // zero amplitude on channel 2: abort on the first tick, then a full run
    drain_ticks();
    program_register(REG_CHANNEL, 32'd2);
    program_register(REG_AMPLITUDE, 32'd0);
    send_tick(CMD_ON, 16'd0, 16'h8000);
    send_tick(CMD_ON, 16'hFFFF, 16'hFFFB);
    repeat (10) send_tick(CMD_NONE, 16'h7FFF, 16'd5);

    // channel 4 ignores feedback; channel and amplitude changed mid-ramp,
    // then switch off with the exit write on channel 3
    drain_ticks();
    program_register(REG_CHANNEL, 32'd4);
    program_register(REG_AMPLITUDE, 32'd127);
    send_tick(CMD_ON, 16'h7FFF, 16'h8000);
    send_tick(CMD_NONE, 16'h8000, 16'h7FFF);
    drain_ticks();
    program_register(REG_CHANNEL, 32'd0);
    program_register(REG_AMPLITUDE, 32'hFFFF_FFFF);
    send_tick(CMD_NONE, 16'd0, 16'd0);
    drain_ticks();
    program_register(REG_CHANNEL, 32'd3);
    send_tick(CMD_OFF, 16'd0, 16'd0);

    // invalid channel never starts and gets no exit write
    drain_ticks();
    program_register(REG_CHANNEL, 32'd7);
    send_tick(CMD_ON, 16'd0, 16'd0);
    send_tick(CMD_OFF, 16'd0, 16'd0);

    // random sessions; state carries over so changes land mid-ramp too
    while (sb.requests < TICK_TARGET) begin
      drain_ticks();
      steady = ($urandom_range(0, 99) < 15);
      if ($urandom_range(0, 1) != 0) program_register(REG_CHANNEL, {29'd0, pick_channel()});
      if ($urandom_range(0, 1) != 0) program_register(REG_AMPLITUDE, 32'(pick_amplitude()));
      case ($urandom_range(0, 2))
        0: noise = 0;
        1: noise = 2;
        default: noise = 25;
      endcase
      len = ($urandom_range(0, 99) < 15) ? $urandom_range(100, 140) : $urandom_range(4, 40);
      for (k = 0; k < len; k++) begin
        cmd = (k == 0 && $urandom_range(0, 99) < 60) ? CMD_ON : pick_command();
        send_tick(cmd, pick_feedback(noise), pick_feedback(noise));
      end
    end

    drain_ticks();
    repeat (6) @(posedge clk);
    $display("Ran %0d ticks, checked %0d results with %0d analog writes.",
             sb.requests, sb.results, sb.writes);
    $display("Ramps completed: %0d, feedback aborts: %0d, mismatches: %0d.",
             sb.completions, sb.aborts, sb.errors);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/atrs_pkg.sv
rtl/core/atrs_step.sv
rtl/core/analog_test_ramp_sequencer_core.sv
dv/atrs_ramp_scoreboard_pkg.sv
dv/tb.sv
